FILE: hw/rtl/matinv_pkg.sv
// Shared types and constants for the 3x3 matrix inverse pipeline.
`default_nettype none
package matinv_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned ThrW = 31;
  localparam int unsigned ProdW = 64;
  localparam int unsigned AdjW = 65;
  localparam int unsigned DetW = 97;
  localparam int unsigned DW = 96;
  localparam int unsigned QB = 33;
  localparam int unsigned RW = DW + QB;

  typedef struct packed {
    logic signed [31:0] a00;
    logic signed [31:0] a01;
    logic signed [31:0] a02;
    logic signed [31:0] a10;
    logic signed [31:0] a11;
    logic signed [31:0] a12;
    logic signed [31:0] a20;
    logic signed [31:0] a21;
    logic signed [31:0] a22;
  } in_t;

  typedef struct packed {
    logic signed [31:0] b00;
    logic signed [31:0] b01;
    logic signed [31:0] b02;
    logic signed [31:0] b10;
    logic signed [31:0] b11;
    logic signed [31:0] b12;
    logic signed [31:0] b20;
    logic signed [31:0] b21;
    logic signed [31:0] b22;
    logic               singular;
    logic               saturated;
  } out_t;

  function automatic logic [31:0] mag32(logic [31:0] x);
    return x[31] ? (32'd0 - x) : x;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/matrix3_inverse.sv
// Top level: fully pipelined 3x3 fixed-point matrix inverse by adjugate.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_req_i) carries one 3x3
//   matrix of signed Q16.16 elements per request, row-major.
//   Output channel (out_valid_o / out_ready_i / out_req_o) returns the
//   inverse, truncated toward zero and clamped to Q16.16, plus the
//   singular and saturated flags.
//   cfg_we_i / cfg_wdata_i write det_threshold (reset value 1); write it
//   only while no request is in flight.
// Pipeline: 40 register stages.
// Throughput: one request per cycle when out_ready_i does not stall. Five
//   stages form products, the adjugate and the determinant; one stage picks
//   the divisor; 33 stages each retire one quotient bit of nine restoring
//   dividers; the last register clamps and holds the result.
// Reset clears every stage valid bit and loads the threshold with 1.
// Stalls: each stage advances when it is empty or its successor advances,
//   so bubbles collapse and in_ready_o drops only once every stage holds a
//   request and the receiver holds out_ready_i low.
`default_nettype none
module matrix3_inverse
  import matinv_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output      logic           in_ready_o,
  input  wire in_t            in_req_i,
  output      logic           out_valid_o,
  input  wire logic           out_ready_i,
  output      out_t           out_req_o,
  input  wire logic           cfg_we_i,
  input  wire logic [ThrW-1:0] cfg_wdata_i
);

  // cofactor k = el[P]*el[Q] - el[R]*el[S]
  localparam logic [3:0] IdxP [9] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
  localparam logic [3:0] IdxQ [9] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
  localparam logic [3:0] IdxR [9] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
  localparam logic [3:0] IdxS [9] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QB-1:0] q;
    logic          neg;
    logic          ovf;
  } lane_t;

  typedef struct packed {
    lane_t [8:0]   lane;
    logic [DW-1:0] d;
    logic          singular;
  } dv_t;

  logic [ThrW-1:0] det_threshold_q;

  // stage registers
  logic                  p1_v_q, p2_v_q, p3_v_q, p4_v_q, p5_v_q;
  logic [8:0][ProdW-1:0] p1_pa_q, p1_pb_q;
  logic [8:0]            p1_sa_q, p1_sb_q;
  logic [2:0][31:0]      p1_am_q, p2_am_q;
  logic [2:0]            p1_an_q, p2_an_q;
  logic [8:0][AdjW-1:0]  p2_adj_q, p3_adj_q, p4_adj_q, p5_adj_q;
  logic [2:0][63:0]      p3_lo_q, p3_hi_q;
  logic [2:0]            p3_neg_q;
  logic [2:0][DetW-1:0]  p4_t_q;
  logic [DetW-1:0]       p5_det_q;

  dv_t  dv_q   [QB+1];
  logic dv_v_q [QB+1];
  logic en_dv  [QB+1];

  logic en_p1, en_p2, en_p3, en_p4, en_p5, en_out;
  logic out_v_q;
  out_t out_q;

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_threshold_q <= ThrW'(1);
    end else if (cfg_we_i) begin
      det_threshold_q <= cfg_wdata_i;
    end
  end

  // ---------------- advance chain: a stage moves when empty or drained ----
  assign en_out      = !out_v_q || out_ready_i;
  assign en_dv[QB]   = !dv_v_q[QB] || en_out;
  for (genvar j = 0; j < QB; j++) begin : g_en
    assign en_dv[j] = !dv_v_q[j] || en_dv[j+1];
  end
  assign en_p5      = !p5_v_q || en_dv[0];
  assign en_p4      = !p4_v_q || en_p5;
  assign en_p3      = !p3_v_q || en_p4;
  assign en_p2      = !p2_v_q || en_p3;
  assign en_p1      = !p1_v_q || en_p2;
  assign in_ready_o = en_p1;

  // ---------------- stage 1: 18 element products ----------------
  logic [8:0][31:0] el;
  assign el = {in_req_i.a22, in_req_i.a21, in_req_i.a20, in_req_i.a12, in_req_i.a11,
               in_req_i.a10, in_req_i.a02, in_req_i.a01, in_req_i.a00};

  logic [8:0][ProdW-1:0] p1_pa_d, p1_pb_d;
  logic [8:0]            p1_sa_d, p1_sb_d;
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      p1_pa_d[k] = mag32(el[IdxP[k]]) * mag32(el[IdxQ[k]]);
      p1_pb_d[k] = mag32(el[IdxR[k]]) * mag32(el[IdxS[k]]);
      p1_sa_d[k] = el[IdxP[k]][31] ^ el[IdxQ[k]][31];
      p1_sb_d[k] = el[IdxR[k]][31] ^ el[IdxS[k]][31];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_p1) begin
      p1_pa_q <= p1_pa_d;
      p1_pb_q <= p1_pb_d;
      p1_sa_q <= p1_sa_d;
      p1_sb_q <= p1_sb_d;
      p1_am_q <= {mag32(el[6]), mag32(el[3]), mag32(el[0])};
      p1_an_q <= {el[6][31], el[3][31], el[0][31]};
    end
  end

  // ---------------- stage 2: adjugate terms ----------------
  logic [8:0][AdjW-1:0] p2_adj_d;
  always_comb begin
    logic [AdjW-1:0] ta, tb;
    for (int k = 0; k < 9; k++) begin
      ta = {1'b0, p1_pa_q[k]};
      tb = {1'b0, p1_pb_q[k]};
      if (p1_sa_q[k]) ta = AdjW'(0) - ta;
      if (p1_sb_q[k]) tb = AdjW'(0) - tb;
      p2_adj_d[k] = ta - tb;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_p2) begin
      p2_adj_q <= p2_adj_d;
      p2_am_q  <= p1_am_q;
      p2_an_q  <= p1_an_q;
    end
  end

  // ---------------- stage 3: first-column partial products ----------------
  logic [2:0][63:0] p3_lo_d, p3_hi_d;
  logic [2:0]       p3_neg_d;
  always_comb begin
    logic [AdjW-1:0] am;
    for (int c = 0; c < 3; c++) begin
      am = p2_adj_q[c][AdjW-1] ? (AdjW'(0) - p2_adj_q[c]) : p2_adj_q[c];
      p3_lo_d[c]  = p2_am_q[c] * am[31:0];
      p3_hi_d[c]  = p2_am_q[c] * am[63:32];
      p3_neg_d[c] = p2_an_q[c] ^ p2_adj_q[c][AdjW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_p3) begin
      p3_lo_q  <= p3_lo_d;
      p3_hi_q  <= p3_hi_d;
      p3_neg_q <= p3_neg_d;
      p3_adj_q <= p2_adj_q;
    end
  end

  // ---------------- stage 4: merge partials, apply sign ----------------
  logic [2:0][DetW-1:0] p4_t_d;
  always_comb begin
    logic [DetW-1:0] tm;
    for (int c = 0; c < 3; c++) begin
      tm = {p3_hi_q[c][63:0], 32'd0} + DetW'(p3_lo_q[c]);
      p4_t_d[c] = p3_neg_q[c] ? (DetW'(0) - tm) : tm;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_p4) begin
      p4_t_q   <= p4_t_d;
      p4_adj_q <= p3_adj_q;
    end
  end

  // ---------------- stage 5: determinant ----------------
  always_ff @(posedge clk_i) begin
    if (en_p5) begin
      p5_det_q <= p4_t_q[0] + p4_t_q[1] + p4_t_q[2];
      p5_adj_q <= p4_adj_q;
    end
  end

  // ---------------- stage 6: divisor select, numerators ----------------
  dv_t dv0_d;
  always_comb begin
    logic [DetW-1:0] dm;
    logic [DW-1:0]   thr;
    logic [AdjW-1:0] am;
    logic            dneg;
    dm  = p5_det_q[DetW-1] ? (DetW'(0) - p5_det_q) : p5_det_q;
    thr = DW'(det_threshold_q) << (2 * FRAC_BITS);
    dv0_d.singular = (p5_det_q == '0) || (dm[DW-1:0] < thr);
    dv0_d.d = dv0_d.singular ? (DW'(1) << (3 * FRAC_BITS)) : dm[DW-1:0];
    dneg = !dv0_d.singular && p5_det_q[DetW-1];
    for (int k = 0; k < 9; k++) begin
      am = p5_adj_q[k][AdjW-1] ? (AdjW'(0) - p5_adj_q[k]) : p5_adj_q[k];
      dv0_d.lane[k].rem = RW'(am[63:0]) << (2 * FRAC_BITS);
      dv0_d.lane[k].q   = '0;
      dv0_d.lane[k].neg = p5_adj_q[k][AdjW-1] ^ dneg;
      dv0_d.lane[k].ovf = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_dv[0]) begin
      dv_q[0] <= dv0_d;
    end
  end

  // ---------------- divider: one quotient bit per stage ----------------
  for (genvar j = 1; j <= QB; j++) begin : g_div
    dv_t st_d;
    always_comb begin
      logic [RW-1:0] sh;
      st_d = dv_q[j-1];
      sh   = RW'(dv_q[j-1].d) << (QB - j);
      for (int k = 0; k < 9; k++) begin
        // range check beside the first quotient bit
        if (j == 1) begin
          st_d.lane[k].ovf = dv_q[j-1].lane[k].rem >= (RW'(dv_q[j-1].d) << QB);
        end
        if (dv_q[j-1].lane[k].rem >= sh) begin
          st_d.lane[k].rem        = dv_q[j-1].lane[k].rem - sh;
          st_d.lane[k].q[QB - j]  = 1'b1;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_dv[j]) begin
        dv_q[j] <= st_d;
      end
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
      p4_v_q <= 1'b0;
      p5_v_q <= 1'b0;
      for (int j = 0; j <= QB; j++) dv_v_q[j] <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en_p1) p1_v_q <= in_valid_i;
      if (en_p2) p2_v_q <= p1_v_q;
      if (en_p3) p3_v_q <= p2_v_q;
      if (en_p4) p4_v_q <= p3_v_q;
      if (en_p5) p5_v_q <= p4_v_q;
      if (en_dv[0]) dv_v_q[0] <= p5_v_q;
      for (int j = 1; j <= QB; j++) begin
        if (en_dv[j]) dv_v_q[j] <= dv_v_q[j-1];
      end
      if (en_out) out_v_q <= dv_v_q[QB];
    end
  end

  // ---------------- output: sign, clamp, hold ----------------
  out_t out_d;
  always_comb begin
    logic [8:0][31:0] b;
    logic             sat;
    logic             big;
    lane_t            ln;
    sat = 1'b0;
    for (int k = 0; k < 9; k++) begin
      ln = dv_q[QB].lane[k];
      if (ln.neg) begin
        big  = ln.ovf || (ln.q > QB'(33'h0_8000_0000));
        b[k] = big ? 32'h8000_0000 : (32'd0 - ln.q[31:0]);
      end else begin
        big  = ln.ovf || ln.q[QB-1] || ln.q[31];
        b[k] = big ? 32'h7FFF_FFFF : ln.q[31:0];
      end
      sat = sat | big;
    end
    out_d.b00 = b[0];
    out_d.b01 = b[1];
    out_d.b02 = b[2];
    out_d.b10 = b[3];
    out_d.b11 = b[4];
    out_d.b12 = b[5];
    out_d.b20 = b[6];
    out_d.b21 = b[7];
    out_d.b22 = b[8];
    out_d.singular  = dv_q[QB].singular;
    out_d.saturated = sat;
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_req_o   = out_q;

endmodule
`default_nettype wire

FILE: hw/rtl/matinv_checker.sv
// Port-level checker for the matrix inverse, bound to the top level.
`default_nettype none
module matinv_checker
  import matinv_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire out_t out_req_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_req_o))
    else $error("stalled result changed");

  // back-pressure only while a result is held and the sink stalls
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with room in pipeline");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result present right after reset");

endmodule

bind matrix3_inverse matinv_checker u_matinv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_req_o   (out_req_o)
);
`default_nettype wire

FILE: test/matrix3_inverse_test.sv
// Testbench for matrix3_inverse: random and directed matrices checked against a local predictor.
`default_nettype none
module matrix3_inverse_test;
  import matinv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency     = 40;
  localparam int IdleLimit   = 10000;
  localparam int HoldCycles  = 400;
  localparam int RandPerPass = 206;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  in_t        in_req_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_t       out_req_o;
  logic       cfg_we_i = 1'b0;
  logic [ThrW-1:0] cfg_wdata_i = '0;

  matrix3_inverse dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_req_i,
    .out_valid_o, .out_ready_i, .out_req_o, .cfg_we_i, .cfg_wdata_i
  );

  always #6 clk_i = ~clk_i;

  // Requests waiting to be offered, and inverses still owed by the block.
  in_t  matrix_queue[$];
  out_t inverse_queue[$];

  logic [ThrW-1:0] threshold = 31'd1;  // mirror of det_threshold
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int mismatches      = 0;
  bit hold_start      = 1'b0;
  int hold_left       = 0;
  bit in_taken        = 1'b0;
  int idle_cycles     = 0;

  // Exact adjugate inverse: wide products, truncation toward zero, clamp.
  function automatic out_t predict_inverse(in_t m, logic [ThrW-1:0] thr);
    logic signed [127:0] e[9];
    logic signed [127:0] adj[9];
    logic signed [127:0] det;
    logic [127:0] dmag, divisor, num, quo, thr_w;
    logic singular, det_neg, neg, sat;
    logic [31:0] v;
    out_t r;
    r = '0;
    sat = 1'b0;
    for (int k = 0; k < 9; k++) e[k] = $signed(m[287-32*k -: 32]);
    adj[0] = e[4]*e[8] - e[5]*e[7];
    adj[1] = e[2]*e[7] - e[1]*e[8];
    adj[2] = e[1]*e[5] - e[2]*e[4];
    adj[3] = e[5]*e[6] - e[3]*e[8];
    adj[4] = e[0]*e[8] - e[2]*e[6];
    adj[5] = e[2]*e[3] - e[0]*e[5];
    adj[6] = e[3]*e[7] - e[4]*e[6];
    adj[7] = e[1]*e[6] - e[0]*e[7];
    adj[8] = e[0]*e[4] - e[1]*e[3];
    det = e[0]*adj[0] + e[3]*adj[1] + e[6]*adj[2];
    dmag = (det < 0) ? $unsigned(-det) : $unsigned(det);
    thr_w = 128'(thr) << (2*FRAC_BITS);
    // A zero determinant is singular even with a zero threshold.
    singular = (det == 0) || (dmag < thr_w);
    divisor = singular ? (128'd1 << (3*FRAC_BITS)) : dmag;
    det_neg = singular ? 1'b0 : (det < 0);
    for (int k = 0; k < 9; k++) begin
      num = ((adj[k] < 0) ? $unsigned(-adj[k]) : $unsigned(adj[k])) << (2*FRAC_BITS);
      quo = num / divisor;
      neg = (adj[k] < 0) ^ det_neg;
      if (neg) begin
        if (quo > 128'h8000_0000) begin
          quo = 128'h8000_0000;
          sat = 1'b1;
        end
        v = 32'd0 - quo[31:0];
      end else begin
        if (quo > 128'h7FFF_FFFF) begin
          quo = 128'h7FFF_FFFF;
          sat = 1'b1;
        end
        v = quo[31:0];
      end
      r[289-32*k -: 32] = v;
    end
    r.singular  = singular;
    r.saturated = sat;
    return r;
  endfunction

  function automatic logic [31:0] small_elem();
    logic [31:0] x;
    x = $urandom_range(0, 32'h0006_0000);
    return $urandom_range(0, 1) ? -x : x;
  endfunction

  // Mostly well-conditioned Q16.16 matrices, with singular, diagonal and full-range noise.
  function automatic in_t random_matrix();
    in_t m;
    int kind;
    m = '0;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 9; k++)
      m[287-32*k -: 32] = (kind < 2) ? $urandom() : small_elem();
    if (kind == 2) begin
      m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02;  // repeated row
    end else if (kind == 3) begin
      m.a01 = '0; m.a02 = '0; m.a10 = '0; m.a12 = '0; m.a20 = '0; m.a21 = '0;
    end else if (kind == 4) begin
      m.a00 = $urandom_range(0, 255); m.a11 = $urandom_range(0, 255);  // tiny det
      m.a22 = $urandom_range(0, 255);
      m.a01 = '0; m.a02 = '0; m.a10 = '0; m.a12 = '0; m.a20 = '0; m.a21 = '0;
    end
    return m;
  endfunction

  function automatic in_t diag(logic [31:0] d0, logic [31:0] d1, logic [31:0] d2);
    in_t m;
    m = '0;
    m.a00 = d0; m.a11 = d1; m.a22 = d2;
    return m;
  endfunction

  function automatic in_t fill_all(logic [31:0] x);
    in_t m;
    for (int k = 0; k < 9; k++) m[287-32*k -: 32] = x;
    return m;
  endfunction

  // Driver: advance to the next request once the current one is taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (matrix_queue.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        in_req_i   <= matrix_queue.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here so the pipe fills and blocks input.
  always @(negedge clk_i) begin
    if (hold_start && hold_left == 0) hold_left <= HoldCycles;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Predict on every accepted request.
  always @(posedge clk_i) begin
    in_taken = in_valid_i && in_ready_o;
    if (in_taken) inverse_queue.push_back(predict_inverse(in_req_i, threshold));
  end

  // Monitor: compare each returned inverse with the oldest prediction.
  always @(posedge clk_i) begin
    out_t want;
    if (out_valid_o && out_ready_i) begin
      if (inverse_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_req_o);
      end else begin
        want = inverse_queue.pop_front();
        for (int k = 0; k < 9; k++)
          if (out_req_o[289-32*k -: 32] !== want[289-32*k -: 32]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("element %0d: expected %h got %h", k,
                       want[289-32*k -: 32], out_req_o[289-32*k -: 32]);
          end
        if (out_req_o.singular !== want.singular) begin
          mismatches++;
          if (mismatches <= 10)
            $display("singular: expected %b got %b", want.singular, out_req_o.singular);
        end
        if (out_req_o.saturated !== want.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("saturated: expected %b got %b", want.saturated, out_req_o.saturated);
        end
      end
    end
  end

  // Watchdog: drop the run when work is owed but nothing moves.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (matrix_queue.size() == 0 && inverse_queue.size() == 0 && !in_valid_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("** matrix3_inverse: FAILED **");
      $finish;
    end
  end

  task automatic write_threshold(logic [ThrW-1:0] thr);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= thr;
    threshold    = thr;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic drain();
    while (matrix_queue.size() > 0 || in_valid_i || inverse_queue.size() > 0)
      @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  task automatic run_pass(logic [ThrW-1:0] thr, int idle_pct, int stall_pct, bit hold);
    write_threshold(thr);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    for (int i = 0; i < RandPerPass; i++) matrix_queue.push_back(random_matrix());
    if (hold) begin
      @(negedge clk_i);
      hold_start = 1'b1;
      // keep the request up until the hold-off counter has picked it up
      wait (hold_left > 0);
      hold_start = 1'b0;
    end
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: reset threshold first, then the corner matrices.
    matrix_queue.push_back('0);
    matrix_queue.push_back(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    matrix_queue.push_back(diag(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000));
    matrix_queue.push_back(diag(32'h0002_0000, 32'h0004_0000, 32'hFFFE_0000));
    matrix_queue.push_back(diag(32'h0000_0100, 32'h0000_0100, 32'h0000_0100));
    matrix_queue.push_back(diag(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
    matrix_queue.push_back(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    matrix_queue.push_back(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    matrix_queue.push_back(diag(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000));
    matrix_queue.push_back(fill_all(32'h7FFF_FFFF));
    matrix_queue.push_back(fill_all(32'h8000_0000));
    matrix_queue.push_back(fill_all(32'hFFFF_FFFF));
    begin
      in_t m;
      m = fill_all(32'h8000_0000);
      m.a11 = 32'h7FFF_FFFF; m.a02 = 32'h7FFF_FFFF; m.a20 = 32'h0000_0000;
      matrix_queue.push_back(m);
      m = diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      m.a01 = 32'h7FFF_FFFF; m.a12 = 32'h8000_0000;
      matrix_queue.push_back(m);
    end
    matrix_queue.push_back(diag(32'h0000_0001, 32'h0001_0000, 32'h0001_0000));
    drain();
    // Zero threshold: only an exact zero determinant is singular.
    write_threshold('0);
    matrix_queue.push_back('0);
    matrix_queue.push_back(diag(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
    matrix_queue.push_back(diag(32'h0000_0001, 32'h0001_0000, 32'h0001_0000));
    drain();
    // Threshold right at a determinant of 1.0: equal is not singular.
    write_threshold(31'h0001_0000);
    matrix_queue.push_back(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    matrix_queue.push_back(diag(32'h0000_FFFF, 32'h0001_0000, 32'h0001_0000));
    drain();

    run_pass(31'd1, 0, 0, 1'b0);
    run_pass('0, 71, 0, 1'b0);
    run_pass(31'h7FFF_FFFF, 0, 71, 1'b0);
    run_pass(31'h0001_0000, 30, 30, 1'b0);
    run_pass(ThrW'($urandom_range(0, 32'h0004_0000)), 0, 0, 1'b1);

    if (mismatches == 0) $display("** matrix3_inverse: PASSED **");
    else $display("** matrix3_inverse: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire
